// ----- hw/rtl/lkvc_pkg.sv -----
`timescale 1ns / 1ps
package lkvc_pkg;

  // default number of entries
  localparam int unsigned MAX_ENTRIES_DEF = 16;
  // key and value widths are fixed by the word format
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;
  // capacity register
  localparam int unsigned CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef struct packed {
    op_e                   operation;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_AGE,
    ST_AGE_END,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic age_rd;
    logic decide;
    logic commit;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_put;
    logic hit;
    logic slot_ok;
    logic out_full;
  } dp_status_t;

endpackage

// ----- hw/rtl/lru_key_value_cache_unit.sv -----
`timescale 1ns / 1ps
// flow: a get miss goes from acceptance through the scan and decide states to the result word,
//   a hit or a put also runs the age pass before the result word is loaded
// throughput: one word at a time; set by the single read port of the entry memories,
//   walked once for the lookup scan and once for the recency update
// reset: valid bits, fill count and control clear at once, capacity returns to 16

module lru_key_value_cache_unit import lkvc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // capacity register write
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  // request words
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_word_t         in_word_i,
  // result words
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_word_t        out_word_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // controller walks the entry index, datapath holds keys, values and ages
  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [IDX_W-1:0] idx;

  // sequence: accept, scan all slots (match, oldest, first free), decide (read/update
  // data, evict), age pass and commit new key except on a get miss, load result register
  lkvc_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  // result sits in an output register so the next word can start while
  // the previous result waits for the consumer
  lkvc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- hw/rtl/lkvc_datapath.sv -----
`timescale 1ns / 1ps
module lkvc_datapath import lkvc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            cfg_we_i,
  input  logic [CAP_W-1:0]                                cfg_data_i,
  input  in_word_t                                        in_word_i,
  input  dp_cmd_t                                         cmd_i,
  input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] idx_i,
  output dp_status_t                                      status_o,
  input  logic                                            out_ready_i,
  output logic                                            out_valid_o,
  output out_word_t                                       out_word_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = CNT_W + CAP_W;
  localparam logic [CMP_W-1:0] MaxCmp = CMP_W'(MAX_ENTRIES);

  // capacity register
  logic [CAP_W-1:0] cap_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // current word
  op_e                   op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] wval_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_word_i.operation;
      key_q  <= in_word_i.key;
      wval_q <= in_word_i.write_value;
    end
  end

  logic is_put;
  assign is_put = (op_q == OP_PUT);

  // entry state
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]       count_q;
  logic [KEY_BITS-1:0]    key_mem  [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]  data_mem [MAX_ENTRIES];
  logic [IDX_W-1:0]       age_mem  [MAX_ENTRIES];

  logic [KEY_BITS-1:0]   key_rd_q;
  logic [VALUE_BITS-1:0] data_rd_q;
  logic [IDX_W-1:0]      age_rd_q;

  // read lag tracking
  logic             scan_lag_q, age_lag_q;
  logic [IDX_W-1:0] lag_idx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_lag_q <= 1'b0;
      age_lag_q  <= 1'b0;
    end else begin
      scan_lag_q <= cmd_i.scan_rd;
      age_lag_q  <= cmd_i.age_rd;
    end
  end
  always_ff @(posedge clk_i) begin
    lag_idx_q <= idx_i;
  end

  logic rd_valid;
  assign rd_valid = valid_q[lag_idx_q];

  // effective capacity and full flag
  logic [CMP_W-1:0] cap_ext, eff_cap, cnt_ext;
  logic             full;
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > MaxCmp) begin
      eff_cap = MaxCmp;
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign cnt_ext = CMP_W'(count_q);
  assign full    = (cnt_ext >= eff_cap);

  // scan results
  logic             hit_q, vic_found_q, free_found_q;
  logic [IDX_W-1:0] hit_idx_q, vic_idx_q, free_idx_q;
  logic [IDX_W-1:0] hit_age_q, vic_age_q;
  logic             scan_hit, scan_vic, scan_free;

  assign scan_hit  = scan_lag_q && rd_valid && (key_rd_q == key_q) && !hit_q;
  assign scan_vic  = scan_lag_q && rd_valid && (!vic_found_q || (age_rd_q > vic_age_q));
  assign scan_free = scan_lag_q && !rd_valid && !free_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q        <= 1'b0;
      vic_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q        <= 1'b0;
      vic_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (scan_hit)  hit_q        <= 1'b1;
      if (scan_vic)  vic_found_q  <= 1'b1;
      if (scan_free) free_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_hit) begin
      hit_idx_q <= lag_idx_q;
      hit_age_q <= age_rd_q;
    end
    if (scan_vic) begin
      vic_idx_q <= lag_idx_q;
      vic_age_q <= age_rd_q;
    end
    if (scan_free) begin
      free_idx_q <= lag_idx_q;
    end
  end

  // slot choice for a new key: lowest free slot, counting the victim
  logic             evict_now, slot_ok;
  logic [IDX_W-1:0] slot_sel;
  assign evict_now = is_put && !hit_q && full && vic_found_q;
  assign slot_ok   = free_found_q || evict_now;
  always_comb begin
    if (free_found_q) begin
      slot_sel = (evict_now && (vic_idx_q < free_idx_q)) ? vic_idx_q : free_idx_q;
    end else begin
      slot_sel = vic_idx_q;
    end
  end

  logic             ins_q;
  logic [IDX_W-1:0] tgt_q, tgt_age_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_q <= 1'b0;
    end else if (cmd_i.decide) begin
      ins_q <= is_put && !hit_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      tgt_q     <= hit_q ? hit_idx_q : slot_sel;
      tgt_age_q <= hit_age_q;
    end
  end

  // valid bits and fill count
  logic ins_commit;
  assign ins_commit = cmd_i.commit && ins_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (cmd_i.decide && evict_now) begin
      valid_q[vic_idx_q] <= 1'b0;
      count_q            <= count_q - 1'b1;
    end else if (ins_commit) begin
      valid_q[tgt_q] <= 1'b1;
      count_q        <= count_q + 1'b1;
    end
  end

  // key memory
  always_ff @(posedge clk_i) begin
    if (ins_commit) begin
      key_mem[tgt_q] <= key_q;
    end
    if (cmd_i.scan_rd) begin
      key_rd_q <= key_mem[idx_i];
    end
  end

  // data memory
  logic             data_we, data_re;
  logic [IDX_W-1:0] data_wa;
  assign data_we = ins_commit || (cmd_i.decide && is_put && hit_q);
  assign data_re = cmd_i.decide && !is_put && hit_q;
  assign data_wa = ins_commit ? tgt_q : hit_idx_q;
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[data_wa] <= wval_q;
    end
    if (data_re) begin
      data_rd_q <= data_mem[hit_idx_q];
    end
  end

  // age memory, read-modify-write during the age pass
  logic             age_we;
  logic [IDX_W-1:0] age_wd;
  always_comb begin
    age_we = 1'b0;
    age_wd = '0;
    if (age_lag_q) begin
      if (lag_idx_q == tgt_q) begin
        age_we = 1'b1;
      end else if (rd_valid && (ins_q || (age_rd_q < tgt_age_q))) begin
        age_we = 1'b1;
        age_wd = age_rd_q + 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (age_we) begin
      age_mem[lag_idx_q] <= age_wd;
    end
    if (cmd_i.scan_rd || cmd_i.age_rd) begin
      age_rd_q <= age_mem[idx_i];
    end
  end

  // output register
  logic      out_valid_q;
  out_word_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.found      <= hit_q;
      out_q.read_value <= (!is_put && hit_q) ? data_rd_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign status_o.is_put   = is_put;
  assign status_o.hit      = hit_q;
  assign status_o.slot_ok  = slot_ok;
  assign status_o.out_full = out_valid_q && !out_ready_i;

endmodule

// ----- hw/rtl/lkvc_ctrl.sv -----
`timescale 1ns / 1ps
module lkvc_ctrl import lkvc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                                                     clk_i,
  input  logic                                                     rst_ni,
  input  logic                                                     in_valid_i,
  output logic                                                     in_ready_o,
  input  dp_status_t                                               status_i,
  output dp_cmd_t                                                  cmd_o,
  output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] idx_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_ENTRIES - 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last;
  logic             skip_age;

  assign last = (idx_q == LastIdx);
  // get miss, or a put of a new key with nowhere to go
  assign skip_age = status_i.is_put ? (!status_i.hit && !status_i.slot_ok) : !status_i.hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_d = ST_SCAN_END;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (skip_age) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_AGE;
          idx_d   = '0;
        end
      end
      ST_AGE: begin
        if (last) begin
          state_d = ST_AGE_END;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_AGE_END: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN:     cmd_o.scan_rd  = 1'b1;
      ST_DECIDE:   cmd_o.decide   = 1'b1;
      ST_AGE:      cmd_o.age_rd   = 1'b1;
      ST_AGE_END:  cmd_o.commit   = 1'b1;
      ST_DONE:     cmd_o.out_load = !status_i.out_full;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign idx_o = idx_q;

endmodule

// ----- hw/rtl/lkvc_checker.sv -----
`timescale 1ns / 1ps
module lkvc_checker import lkvc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  // one word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while a word is in flight");

  // a new result only comes from a finishing word
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  // misses return zero; a put that hits returns zero too, but this assertion does not check it
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.found |-> out_word_o.read_value == '0)
    else $error("nonzero value without a hit");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
